// File: design/fqn_pkg.sv
package fqn_pkg;

    // name store and counter limits
    localparam int NAME_MAX    = 256;
    localparam int READ_MAX    = 4096;
    localparam int NAME_AW     = $clog2(NAME_MAX);
    localparam int NLEN_W      = $clog2(NAME_MAX + 2);
    localparam int CNT_W       = 13;
    localparam int REP_W       = 16;
    localparam int ERR_W       = 3;

    // queue between the parser and the output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // register map
    localparam int REG_CHECK_REPEATS = 0;
    localparam int PADDR_W           = 3;

    // characters
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UC      = 8'h43;
    localparam logic [7:0] CH_UG      = 8'h47;
    localparam logic [7:0] CH_UT      = 8'h54;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LC      = 8'h63;
    localparam logic [7:0] CH_LG      = 8'h67;
    localparam logic [7:0] CH_LT      = 8'h74;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    // line kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_SEQ  = 2'd1;
    localparam logic [1:0] KIND_PLUS = 2'd2;
    localparam logic [1:0] KIND_QUAL = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_AT     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_PLUS   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LENGTH    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;

    localparam logic [CNT_W-1:0] READ_MAX_C = CNT_W'(READ_MAX);
    localparam logic [CNT_W-1:0] NAME_MAX_C = CNT_W'(NAME_MAX);

    // one classified beat on its way to the output side
    typedef struct packed {
        logic [7:0]        ch;
        logic [1:0]        kind;
        logic              eol;
        logic              done;
        logic [CNT_W-1:0]  rlen;
        logic [CNT_W-1:0]  nbases;
        logic              fix;
        logic [ERR_W-1:0]  err;
        logic              name_start;
        logic              name_end;
        logic              cmp_en;
        logic              over;
        logic [NLEN_W-1:0] idx;
        logic [7:0]        prev_ch;
    } token_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v < READ_MAX_C) ? v + 1'b1 : READ_MAX_C;
    endfunction

endpackage

// File: design/fastq_record_normalizer_top.sv
// path: an accepted byte is registered in the parser output stage, then in the queue, then in the output register
// throughput: one byte per cycle while in_stall is low, set by the single-port name store and the parser stage
// a four-beat queue lets the parser keep accepting while the output stalls
// reset: rst_n is asynchronous, clears parser, queue, counters and check_repeats
// the name store is not cleared; entries are only compared once written
module fastq_record_normalizer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fqn_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_input,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic [1:0]                   line_kind,
    output logic                         end_of_line,
    output logic                         record_done,
    output logic [fqn_pkg::CNT_W-1:0]    read_length,
    output logic [fqn_pkg::CNT_W-1:0]    n_bases,
    output logic [fqn_pkg::REP_W-1:0]    repeat_count,
    output logic                         fix_needed,
    output logic [fqn_pkg::ERR_W-1:0]    error_code
);
    import fqn_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_CHECK_REPEATS = PADDR_W'(4 * REG_CHECK_REPEATS);

    logic   check_repeats_reg;
    logic   cfg_hit;
    logic   q_push, q_full;
    token_t q_wdata, q_rdata;
    logic   q_not_empty, q_pop;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr == ADDR_CHECK_REPEATS);
    assign prdata  = cfg_hit ? {31'd0, check_repeats_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            check_repeats_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && cfg_hit)
            check_repeats_reg <= pwdata[0];
    end

    fqn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .check_repeats (check_repeats_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_input  (end_of_input),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    fqn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .full      (q_full),
        .wdata     (q_wdata),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .rdata     (q_rdata)
    );

    fqn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .check_repeats (check_repeats_reg),
        .q_not_empty   (q_not_empty),
        .q_pop         (q_pop),
        .q_data        (q_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .line_kind     (line_kind),
        .end_of_line   (end_of_line),
        .record_done   (record_done),
        .read_length   (read_length),
        .n_bases       (n_bases),
        .repeat_count  (repeat_count),
        .fix_needed    (fix_needed),
        .error_code    (error_code)
    );

endmodule

// File: design/fqn_front.sv
module fqn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              check_repeats,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_input,
    input  logic              q_full,
    output logic              q_push,
    output fqn_pkg::token_t   q_data
);
    import fqn_pkg::*;

    // parser state
    logic [1:0]       kind_reg, kind_next;
    logic             start_reg, start_next;
    logic [CNT_W-1:0] lbc_reg, lbc_next;
    logic [CNT_W-1:0] seq_reg, seq_next;
    logic [CNT_W-1:0] nb_reg, nb_next;
    logic             cut_reg, cut_next;
    logic             fix_reg, fix_next;
    logic [ERR_W-1:0] err_reg, err_next;
    logic             seen_reg, seen_next;

    // output stage of the parser
    logic             p1_valid_reg, p1_valid_next;
    token_t           p1_reg, p1_next;
    logic             res_valid;
    token_t           tok;

    // name store
    logic [7:0]       name_mem [NAME_MAX];
    logic [7:0]       rdata_reg;
    logic             wr_en;
    logic [NAME_AW-1:0] addr;

    logic accept;

    assign in_stall = p1_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign q_push   = p1_valid_reg & ~q_full;
    assign addr     = lbc_reg[NAME_AW-1:0];

    always_comb
    begin
        q_data         = p1_reg;
        q_data.prev_ch = rdata_reg;
    end

    // classify one byte
    always_comb
    begin
        kind_next  = kind_reg;
        start_next = start_reg;
        lbc_next   = lbc_reg;
        seq_next   = seq_reg;
        nb_next    = nb_reg;
        cut_next   = cut_reg;
        fix_next   = fix_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        wr_en      = 1'b0;
        res_valid  = 1'b0;
        tok        = '0;
        tok.ch     = data_byte;
        tok.kind   = kind_reg;
        tok.eol    = (data_byte == CH_NL);
        tok.idx    = lbc_reg[NLEN_W-1:0];

        if (err_reg != ERR_NONE)
        begin
            res_valid = 1'b0;
        end
        else if (end_of_input)
        begin
            if (kind_reg == KIND_NAME)
            begin
                start_next = 1'b1;
                lbc_next   = '0;
                cut_next   = 1'b0;
            end
            else
            begin
                err_next  = ERR_TRUNCATED;
                res_valid = 1'b1;
                tok.ch    = 8'd0;
                tok.eol   = 1'b0;
            end
        end
        else
        begin
            case (kind_reg)
                KIND_NAME:
                begin
                    if (start_reg)
                    begin
                        res_valid = 1'b1;
                        if (data_byte != CH_AT)
                        begin
                            err_next = ERR_NO_AT;
                        end
                        else
                        begin
                            start_next     = 1'b0;
                            lbc_next       = '0;
                            cut_next       = 1'b0;
                            tok.name_start = 1'b1;
                        end
                    end
                    else if (data_byte == CH_NL)
                    begin
                        res_valid    = 1'b1;
                        tok.name_end = 1'b1;
                        seen_next    = 1'b1;
                        kind_next    = KIND_SEQ;
                        start_next   = 1'b1;
                        seq_next     = '0;
                        nb_next      = '0;
                    end
                    else
                    begin
                        if (!seen_reg && data_byte == CH_SLASH)
                            fix_next = 1'b1;
                        if (cut_reg)
                        begin
                            res_valid = 1'b0;
                        end
                        else if (data_byte == CH_SPACE)
                        begin
                            cut_next = 1'b1;
                            fix_next = 1'b1;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            if (lbc_reg < NAME_MAX_C)
                            begin
                                tok.cmp_en = 1'b1;
                                wr_en      = check_repeats;
                                lbc_next   = lbc_reg + 1'b1;
                            end
                            else
                            begin
                                tok.over = 1'b1;
                                lbc_next = NAME_MAX_C + 1'b1;
                            end
                        end
                    end
                end
                KIND_SEQ:
                begin
                    res_valid = 1'b1;
                    if (data_byte == CH_NL)
                    begin
                        kind_next  = KIND_PLUS;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        start_next = 1'b0;
                        seq_next   = sat_inc(seq_reg);
                        case (data_byte)
                            CH_UA, CH_UC, CH_UG, CH_UT:
                            begin
                                tok.ch = data_byte;
                            end
                            CH_LA, CH_LC, CH_LG, CH_LT:
                            begin
                                tok.ch   = data_byte - CASE_SHIFT;
                                fix_next = 1'b1;
                            end
                            default:
                            begin
                                tok.ch   = CH_N;
                                nb_next  = sat_inc(nb_reg);
                                fix_next = 1'b1;
                            end
                        endcase
                    end
                end
                KIND_PLUS:
                begin
                    res_valid = 1'b1;
                    if (start_reg)
                    begin
                        if (data_byte != CH_PLUS)
                            err_next = ERR_NO_PLUS;
                        else
                            start_next = 1'b0;
                    end
                    else if (data_byte == CH_NL)
                    begin
                        kind_next  = KIND_QUAL;
                        start_next = 1'b1;
                        lbc_next   = '0;
                    end
                end
                default:
                begin
                    res_valid = 1'b1;
                    if (data_byte == CH_NL)
                    begin
                        if (lbc_reg != seq_reg)
                        begin
                            err_next = ERR_LENGTH;
                            fix_next = 1'b1;
                        end
                        else
                        begin
                            kind_next  = KIND_NAME;
                            start_next = 1'b1;
                            tok.done   = 1'b1;
                        end
                    end
                    else
                    begin
                        start_next = 1'b0;
                        lbc_next   = sat_inc(lbc_reg);
                    end
                end
            endcase
        end

        // fields show the state after this byte
        tok.rlen   = seq_next;
        tok.nbases = nb_next;
        tok.fix    = fix_next;
        tok.err    = err_next;
    end

    // parser output stage load
    always_comb
    begin
        p1_valid_next = p1_valid_reg & ~q_push;
        p1_next       = p1_reg;
        if (accept)
        begin
            p1_valid_next = res_valid;
            p1_next       = tok;
        end
    end

    // name store, read before write
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= name_mem[addr];
        if (accept && wr_en)
            name_mem[addr] <= data_byte;
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_NAME;
            start_reg    <= 1'b1;
            lbc_reg      <= '0;
            seq_reg      <= '0;
            nb_reg       <= '0;
            cut_reg      <= 1'b0;
            fix_reg      <= 1'b0;
            err_reg      <= ERR_NONE;
            seen_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            if (accept)
            begin
                kind_reg  <= kind_next;
                start_reg <= start_next;
                lbc_reg   <= lbc_next;
                seq_reg   <= seq_next;
                nb_reg    <= nb_next;
                cut_reg   <= cut_next;
                fix_reg   <= fix_next;
                err_reg   <= err_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

// File: design/fqn_queue.sv
module fqn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  fqn_pkg::token_t   wdata,
    output logic              not_empty,
    input  logic              pop,
    output fqn_pkg::token_t   rdata
);
    import fqn_pkg::*;

    token_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign rdata     = slot_reg[rptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

endmodule

// File: design/fqn_back.sv
module fqn_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       check_repeats,
    input  logic                       q_not_empty,
    output logic                       q_pop,
    input  fqn_pkg::token_t            q_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic [1:0]                 line_kind,
    output logic                       end_of_line,
    output logic                       record_done,
    output logic [fqn_pkg::CNT_W-1:0]  read_length,
    output logic [fqn_pkg::CNT_W-1:0]  n_bases,
    output logic [fqn_pkg::REP_W-1:0]  repeat_count,
    output logic                       fix_needed,
    output logic [fqn_pkg::ERR_W-1:0]  error_code
);
    import fqn_pkg::*;

    // name-compare state
    logic              differs_reg, differs_next;
    logic [NLEN_W-1:0] plen_reg, plen_next;
    logic [REP_W-1:0]  rep_reg, rep_next;
    logic              bfix_reg, bfix_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    token_t            otok_reg;
    logic [REP_W-1:0]  orep_reg;
    logic              ofix_reg;

    assign q_pop = q_not_empty & (~ovalid_reg | ~out_stall);

    // compare and repeat count
    always_comb
    begin
        differs_next = differs_reg;
        plen_next    = plen_reg;
        rep_next     = rep_reg;
        bfix_next    = bfix_reg;
        if (q_data.name_start)
            differs_next = 1'b0;
        if (q_data.cmp_en && ((q_data.idx >= plen_reg) || (q_data.prev_ch != q_data.ch)))
            differs_next = 1'b1;
        if (q_data.over)
            differs_next = 1'b1;
        if (q_data.name_end && check_repeats)
        begin
            if (!differs_reg && q_data.idx == plen_reg)
            begin
                rep_next  = (rep_reg != {REP_W{1'b1}}) ? rep_reg + 1'b1 : rep_reg;
                bfix_next = 1'b1;
            end
            else
            begin
                rep_next = '0;
            end
            plen_next = q_data.idx;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg & out_stall;
        if (q_pop)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            otok_reg <= q_data;
            orep_reg <= rep_next;
            ofix_reg <= q_data.fix | bfix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            differs_reg <= 1'b0;
            plen_reg    <= '0;
            rep_reg     <= '0;
            bfix_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (q_pop)
            begin
                differs_reg <= differs_next;
                plen_reg    <= plen_next;
                rep_reg     <= rep_next;
                bfix_reg    <= bfix_next;
            end
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_byte     = otok_reg.ch;
    assign line_kind    = otok_reg.kind;
    assign end_of_line  = otok_reg.eol;
    assign record_done  = otok_reg.done;
    assign read_length  = otok_reg.rlen;
    assign n_bases      = otok_reg.nbases;
    assign repeat_count = orep_reg;
    assign fix_needed   = ofix_reg;
    assign error_code   = otok_reg.err;

endmodule

// File: design/fqn_checker.sv
module fqn_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [7:0]                 out_byte,
    input  logic [1:0]                 line_kind,
    input  logic                       end_of_line,
    input  logic                       record_done,
    input  logic [fqn_pkg::CNT_W-1:0]  read_length,
    input  logic [fqn_pkg::CNT_W-1:0]  n_bases,
    input  logic [fqn_pkg::ERR_W-1:0]  error_code
);
    import fqn_pkg::*;

    // an error beat is the last one until reset
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && error_code != ERR_NONE) |=> !out_valid)
        else $error("beat delivered after error beat");

    // a record only completes on a clean quality-line newline
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_done) |->
            (end_of_line && line_kind == KIND_QUAL && error_code == ERR_NONE))
        else $error("record_done on a wrong beat");

    // n count never exceeds the read length, and the read length never exceeds READ_MAX
    a_nbases: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (n_bases <= read_length && read_length <= READ_MAX_C))
        else $error("n count or read length out of range");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
        else $error("stalled beat changed");

endmodule

bind fastq_record_normalizer_top fqn_checker u_fqn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .line_kind   (line_kind),
    .end_of_line (end_of_line),
    .record_done (record_done),
    .read_length (read_length),
    .n_bases     (n_bases),
    .error_code  (error_code)
);
